// ----- rtl/core/ubxfr_pkg.sv -----
// ----------------------------------------------------------------------------
// ubxfr_pkg
// Shared types and constants of the binary frame receiver: status codes,
// sync bytes, field widths and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package ubxfr_pkg;

	localparam int BYTE_W = 8;
	localparam int STAT_W = 3;
	localparam int LEN_W  = 7;
	localparam int POS_W  = 6;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

	typedef enum logic [STAT_W-1:0] {
		ST_MORE     = 3'd0,
		ST_BADSYNC  = 3'd1,
		ST_OVERSIZE = 3'd2,
		ST_OK       = 3'd3,
		ST_BADCK    = 3'd4
	} status_t;

	typedef struct packed {
		logic    clear;
		logic    add_sum;
		logic    cap_class;
		logic    cap_id;
		logic    cap_len_lo;
		logic    cap_len_hi;
		logic    store_wr;
		logic    cap_cka;
		logic    rd_first;
		logic    emit_step;
		logic    out_ld;
		logic    out_frame;
		logic    out_data;
		logic    out_last;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic sync_first;
		logic sync_second;
		logic len_over;
		logic len_zero;
		logic held_zero;
		logic fill_done;
		logic ck_ok;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/ubxfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ubxfr_ctrl
// Parser state machine: walks sync, header, payload and checksum phases and
// sequences the emission run of an accepted frame.
// ----------------------------------------------------------------------------
module ubxfr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rx_valid,
	output logic              rx_ready,
	input  ubxfr_pkg::sts_t   sts,
	output ubxfr_pkg::cmd_t   cmd
);
	import ubxfr_pkg::*;

	typedef enum logic [9:0] {
		PH_SYNC1   = 10'b00_0000_0001,
		PH_SYNC2   = 10'b00_0000_0010,
		PH_CLASS   = 10'b00_0000_0100,
		PH_ID      = 10'b00_0000_1000,
		PH_LENLO   = 10'b00_0001_0000,
		PH_LENHI   = 10'b00_0010_0000,
		PH_PAYLOAD = 10'b00_0100_0000,
		PH_CKA     = 10'b00_1000_0000,
		PH_CKB     = 10'b01_0000_0000,
		PH_EMIT    = 10'b10_0000_0000
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   accept;

	assign rx_ready = sts.out_free && (phase_q != PH_EMIT);
	assign accept   = rx_valid && rx_ready;

	always_comb begin
		phase_d = phase_q;
		cmd     = '0;
		cmd.out_status = ST_MORE;
		if (phase_q == PH_EMIT) begin
			if (sts.out_free) begin
				cmd.out_ld     = 1'b1;
				cmd.out_status = ST_OK;
				cmd.out_frame  = 1'b1;
				cmd.out_data   = 1'b1;
				cmd.out_last   = sts.emit_last;
				cmd.emit_step  = 1'b1;
				if (sts.emit_last) begin
					cmd.clear = 1'b1;
					phase_d   = PH_SYNC1;
				end
			end
		end else if (accept) begin
			cmd.out_ld   = 1'b1;
			cmd.out_last = 1'b1;
			case (phase_q)
				PH_SYNC1: begin
					if (sts.sync_first) phase_d = PH_SYNC2;
				end
				PH_SYNC2: begin
					if (sts.sync_second) begin
						phase_d = PH_CLASS;
					end else begin
						cmd.out_status = ST_BADSYNC;
						phase_d = sts.sync_first ? PH_SYNC2 : PH_SYNC1;
					end
				end
				PH_CLASS: begin
					cmd.cap_class = 1'b1;
					cmd.add_sum   = 1'b1;
					phase_d       = PH_ID;
				end
				PH_ID: begin
					cmd.cap_id  = 1'b1;
					cmd.add_sum = 1'b1;
					phase_d     = PH_LENLO;
				end
				PH_LENLO: begin
					cmd.cap_len_lo = 1'b1;
					cmd.add_sum    = 1'b1;
					phase_d        = PH_LENHI;
				end
				PH_LENHI: begin
					if (sts.len_over) begin
						cmd.clear      = 1'b1;
						cmd.out_status = ST_OVERSIZE;
						phase_d        = PH_SYNC1;
					end else begin
						cmd.cap_len_hi = 1'b1;
						cmd.add_sum    = 1'b1;
						phase_d        = sts.len_zero ? PH_CKA : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					cmd.store_wr = 1'b1;
					cmd.add_sum  = 1'b1;
					if (sts.fill_done) phase_d = PH_CKA;
				end
				PH_CKA: begin
					cmd.cap_cka = 1'b1;
					phase_d     = PH_CKB;
				end
				PH_CKB: begin
					if (!sts.ck_ok) begin
						cmd.clear      = 1'b1;
						cmd.out_status = ST_BADCK;
						phase_d        = PH_SYNC1;
					end else if (sts.held_zero) begin
						cmd.clear      = 1'b1;
						cmd.out_status = ST_OK;
						cmd.out_frame  = 1'b1;
						phase_d        = PH_SYNC1;
					end else begin
						// read the first word of the run; the store read is registered
						cmd.out_ld   = 1'b0;
						cmd.out_last = 1'b0;
						cmd.rd_first = 1'b1;
						phase_d      = PH_EMIT;
					end
				end
				default: begin
					cmd.clear      = 1'b1;
					cmd.out_status = ST_BADSYNC;
					phase_d        = PH_SYNC1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) phase_q <= PH_SYNC1;
		else         phase_q <= phase_d;
	end

endmodule

// ----- rtl/core/ubxfr_dp.sv -----
// ----------------------------------------------------------------------------
// ubxfr_dp
// Datapath: header capture, Fletcher-8 sums, payload store, emission counter
// and the result register.
// ----------------------------------------------------------------------------
module ubxfr_dp #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [ubxfr_pkg::BYTE_W-1:0]      rx_byte,
	input  logic                              res_stall,
	input  ubxfr_pkg::cmd_t                   cmd,
	output ubxfr_pkg::sts_t                   sts,
	output logic                              res_valid,
	output logic [ubxfr_pkg::STAT_W-1:0]      status,
	output logic [ubxfr_pkg::BYTE_W-1:0]      frame_class,
	output logic [ubxfr_pkg::BYTE_W-1:0]      frame_id,
	output logic [ubxfr_pkg::LEN_W-1:0]       frame_length,
	output logic [ubxfr_pkg::BYTE_W-1:0]      data_byte,
	output logic [ubxfr_pkg::POS_W-1:0]       data_position,
	output logic                              last
);
	import ubxfr_pkg::*;

	logic [BYTE_W-1:0] class_q;
	logic [BYTE_W-1:0] id_q;
	logic [BYTE_W-1:0] len_lo_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  fill_q;
	logic [BYTE_W-1:0] sum_a_q;
	logic [BYTE_W-1:0] sum_b_q;
	logic [BYTE_W-1:0] cka_q;
	logic [POS_W-1:0]  emit_q;
	logic [BYTE_W-1:0] sum_a_nxt;
	logic [15:0]       len_full;

	logic [BYTE_W-1:0] payload_mem [2**POS_W];
	logic [BYTE_W-1:0] rd_q;
	logic [POS_W-1:0]  rd_addr;
	logic              rd_en;

	logic              valid_q;
	status_t           status_q;
	logic [BYTE_W-1:0] class_o_q;
	logic [BYTE_W-1:0] id_o_q;
	logic [LEN_W-1:0]  len_o_q;
	logic [BYTE_W-1:0] data_o_q;
	logic [POS_W-1:0]  pos_o_q;
	logic              last_o_q;

	assign sum_a_nxt = sum_a_q + rx_byte;
	assign len_full  = {rx_byte, len_lo_q};

	always_comb begin
		sts.sync_first  = (rx_byte == SYNC_FIRST);
		sts.sync_second = (rx_byte == SYNC_SECOND);
		sts.len_over    = (len_full > 16'(MAX_PAYLOAD));
		sts.len_zero    = (len_full == 16'd0);
		sts.held_zero   = (len_q == '0);
		sts.fill_done   = ((fill_q + 7'd1) >= len_q);
		sts.ck_ok       = (cka_q == sum_a_q) && (rx_byte == sum_b_q);
		sts.emit_last   = (({1'b0, emit_q} + 7'd1) == len_q);
		sts.out_free    = !valid_q || !res_stall;
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q  <= '0;
			id_q     <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			fill_q   <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			cka_q    <= '0;
		end else if (cmd.clear) begin
			class_q  <= '0;
			id_q     <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			fill_q   <= '0;
			sum_a_q  <= '0;
			sum_b_q  <= '0;
			cka_q    <= '0;
		end else begin
			if (cmd.add_sum) begin
				sum_a_q <= sum_a_nxt;
				sum_b_q <= sum_b_q + sum_a_nxt;
			end
			if (cmd.cap_class)  class_q  <= rx_byte;
			if (cmd.cap_id)     id_q     <= rx_byte;
			if (cmd.cap_len_lo) len_lo_q <= rx_byte;
			if (cmd.cap_len_hi) begin
				len_q  <= len_full[LEN_W-1:0];
				fill_q <= '0;
			end
			if (cmd.store_wr)   fill_q   <= fill_q + 7'd1;
			if (cmd.cap_cka)    cka_q    <= rx_byte;
		end
	end

	// emission counter and store read
	assign rd_en   = cmd.rd_first || (cmd.emit_step && !sts.emit_last);
	assign rd_addr = cmd.rd_first ? '0 : (emit_q + 6'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       emit_q <= '0;
		else if (rd_en)    emit_q <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) payload_mem[fill_q[POS_W-1:0]] <= rx_byte;
		if (rd_en)        rd_q <= payload_mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)              valid_q <= 1'b0;
		else if (cmd.out_ld)      valid_q <= 1'b1;
		else if (!res_stall)      valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			status_q  <= cmd.out_status;
			last_o_q  <= cmd.out_last;
			class_o_q <= cmd.out_frame ? class_q : '0;
			id_o_q    <= cmd.out_frame ? id_q : '0;
			len_o_q   <= cmd.out_frame ? len_q : '0;
			data_o_q  <= cmd.out_data ? rd_q : '0;
			pos_o_q   <= cmd.out_data ? emit_q : '0;
		end
	end

	assign res_valid     = valid_q;
	assign status        = status_q;
	assign frame_class   = class_o_q;
	assign frame_id      = id_o_q;
	assign frame_length  = len_o_q;
	assign data_byte     = data_o_q;
	assign data_position = pos_o_q;
	assign last          = last_o_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= 7'(MAX_PAYLOAD))
		else $error("held length above buffer size");

	a_store_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> (fill_q < len_q))
		else $error("payload write beyond frame length");

	a_emit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |-> ({1'b0, emit_q} < len_q))
		else $error("emission past frame length");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q != ST_OK) |-> last_o_q)
		else $error("status word without last mark");

endmodule

// ----- rtl/core/ubx_frame_receiver_unit.sv -----
// ----------------------------------------------------------------------------
// ubx_frame_receiver_unit
// Binary frame receiver with Fletcher-8 check, one stream byte per word.
// ----------------------------------------------------------------------------
// usage:
//   rx channel (rx_valid/rx_stall/rx_byte) takes one serial byte per word.
//   res channel (res_valid/res_stall + result fields) gives one status word
//   per byte: need more, bad sync, oversize, ok or bad checksum; a good
//   frame with payload gives for its last byte a run of ok words, one per
//   payload byte, last set on the final one; an empty frame, one ok word.
// order and throughput:
//   a byte is taken and its status word is shown the cycle after; one byte
//   per cycle while results drain, except during an emission run.
//   after the final checksum byte of a good frame the run's first word
//   passes the store read register, then the result register; the run gives
//   one word per cycle unless stalled, with rx_stall high throughout.
// reset:
//   arst_n returns the parser to sync hunting and empties the result
//   register; the payload store is not cleared.
// stall:
//   while res_stall holds a pending word, rx_stall stays high and the
//   emission run pauses, nothing is dropped.
// ----------------------------------------------------------------------------
module ubx_frame_receiver_unit #(
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rx_valid,
	output logic                              rx_stall,
	input  logic [ubxfr_pkg::BYTE_W-1:0]      rx_byte,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [ubxfr_pkg::STAT_W-1:0]      status,
	output logic [ubxfr_pkg::BYTE_W-1:0]      frame_class,
	output logic [ubxfr_pkg::BYTE_W-1:0]      frame_id,
	output logic [ubxfr_pkg::LEN_W-1:0]       frame_length,
	output logic [ubxfr_pkg::BYTE_W-1:0]      data_byte,
	output logic [ubxfr_pkg::POS_W-1:0]       data_position,
	output logic                              last
);
	import ubxfr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic rx_ready;

	assign rx_stall = !rx_ready;

	ubxfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ubxfr_dp #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_byte       (rx_byte),
		.res_stall     (res_stall),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.status        (status),
		.frame_class   (frame_class),
		.frame_id      (frame_id),
		.frame_length  (frame_length),
		.data_byte     (data_byte),
		.data_position (data_position),
		.last          (last)
	);

endmodule
